// File: rtl/core/pih_pkg.sv
// pih_pkg: shared types and constants for the content index hash table
// field widths, command and status codes, configuration register indexes
// no dependencies
package pih_pkg;

    localparam int DIGEST_BITS     = 64;
    localparam int DIGEST_LOW_BITS = 32;
    localparam int SIZE_BITS       = 48;
    localparam int SLOT_PORT_BITS  = 10;
    localparam int TABLE_SIZE_BITS = 11;
    localparam int CFG_DATA_BITS   = 48;
    localparam int RADIX_BITS      = 2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic CFG_TABLE_SIZE  = 1'b0;
    localparam logic CFG_BASE_OFFSET = 1'b1;

endpackage

// File: rtl/core/pack_index_hash_insert_top.sv
// pack_index_hash_insert_top: open-addressing content index with linear probing
// slot memories, probe sequencer, output register, configuration registers
// depends on pih_pkg and pih_mod_unit
//
// Usage: an input item is accepted when in_valid is high and in_stall low.
// command insert hashes digest_high modulo the live table size and walks
// upward with wrap-around, one slot read a cycle, to the first empty slot,
// which takes the digest, the size and the running byte offset.
// command read returns one slot. Each item gives exactly one result item,
// held in an output register until out_valid is high and out_stall low.
// A read result passes ST_DONE and then the output register; an insert result
// first waits for the modulo and then for the probe walk past the occupied
// slots; the next item can be taken in the cycle in which the result is offered.
// The 64-bit modulo runs at two bits a cycle, then the probe walk
// reads the valid memory one slot a cycle. One item is in work at a time.
// After reset the valid memory is cleared, one slot a cycle, and in_stall
// stays high meanwhile. While a result waits in
// the output register the next item is still taken, but its result and any
// later item wait until the held result is taken.
// Configuration writes go to cfg_index 0 (table size) and 1 (base offset).
module pack_index_hash_insert_top
    import pih_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [DIGEST_BITS-1:0]     digest_high,
    input  logic [DIGEST_BITS-1:0]     digest_middle,
    input  logic [DIGEST_LOW_BITS-1:0] digest_low,
    input  logic [SIZE_BITS-1:0]       object_size,
    input  logic [SLOT_PORT_BITS-1:0]  read_slot,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SLOT_PORT_BITS-1:0]  slot,
    output logic                       entry_valid,
    output logic [SIZE_BITS-1:0]       entry_offset,
    output logic [SIZE_BITS-1:0]       entry_size,
    output logic [DIGEST_BITS-1:0]     entry_digest_high,
    output logic [DIGEST_BITS-1:0]     entry_digest_middle,
    output logic [DIGEST_LOW_BITS-1:0] entry_digest_low,
    output status_t                    status
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS  = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_READ,
        KIND_EMPTY
    } kind_t;

    // configuration
    logic [TABLE_SIZE_BITS-1:0] table_size_reg;
    logic [SIZE_BITS-1:0]       base_offset_reg;
    logic [CNT_BITS-1:0]        n_live;

    // sequencer
    state_t                     state_reg, state_next;
    kind_t                      kind_reg, kind_next;
    logic [SLOT_BITS-1:0]       clr_addr_reg, clr_addr_next;
    logic [CNT_BITS-1:0]        n_reg, n_next;
    logic [DIGEST_BITS-1:0]     digh_reg, digh_next;
    logic [DIGEST_BITS-1:0]     digm_reg, digm_next;
    logic [DIGEST_LOW_BITS-1:0] digl_reg, digl_next;
    logic [SIZE_BITS-1:0]       size_reg, size_next;
    logic [SLOT_PORT_BITS-1:0]  res_slot_reg, res_slot_next;
    status_t                    res_status_reg, res_status_next;
    logic [SLOT_BITS-1:0]       home_reg, home_next;
    logic [SLOT_BITS-1:0]       probe_addr_reg, probe_addr_next;
    logic                       flight_reg, flight_next;
    logic [SLOT_BITS-1:0]       flight_addr_reg, flight_addr_next;
    logic [CNT_BITS-1:0]        checked_reg, checked_next;
    logic [SLOT_BITS-1:0]       found_reg, found_next;
    logic [OFFSET_BITS-1:0]     bytes_reg, bytes_next;
    logic [OFFSET_BITS-1:0]     new_offset;
    logic [SLOT_BITS-1:0]       probe_wrap;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [SLOT_PORT_BITS-1:0]  slot_reg, slot_next;
    logic                       entry_valid_reg, entry_valid_next;
    logic [SIZE_BITS-1:0]       entry_offset_reg, entry_offset_next;
    logic [SIZE_BITS-1:0]       entry_size_reg, entry_size_next;
    logic [DIGEST_BITS-1:0]     entry_dh_reg, entry_dh_next;
    logic [DIGEST_BITS-1:0]     entry_dm_reg, entry_dm_next;
    logic [DIGEST_LOW_BITS-1:0] entry_dl_reg, entry_dl_next;
    status_t                    status_reg, status_next;

    // memories
    logic                       valid_mem [TABLE_SLOTS];
    logic [OFFSET_BITS-1:0]     offset_mem [TABLE_SLOTS];
    logic [SIZE_BITS-1:0]       size_mem [TABLE_SLOTS];
    logic [DIGEST_BITS-1:0]     dh_mem [TABLE_SLOTS];
    logic [DIGEST_BITS-1:0]     dm_mem [TABLE_SLOTS];
    logic [DIGEST_LOW_BITS-1:0] dl_mem [TABLE_SLOTS];
    logic                       vrd_reg;
    logic [OFFSET_BITS-1:0]     off_rd_reg;
    logic [SIZE_BITS-1:0]       size_rd_reg;
    logic [DIGEST_BITS-1:0]     dh_rd_reg;
    logic [DIGEST_BITS-1:0]     dm_rd_reg;
    logic [DIGEST_LOW_BITS-1:0] dl_rd_reg;

    logic                       vmem_re;
    logic [SLOT_BITS-1:0]       vmem_raddr;
    logic                       vmem_we;
    logic [SLOT_BITS-1:0]       vmem_waddr;
    logic                       vmem_wdata;
    logic                       dmem_re;
    logic                       dmem_we;

    logic                       mod_start;
    logic                       mod_done;
    logic [CNT_BITS-1:0]        mod_rem;

    pih_mod_unit #(
        .CNT_BITS (CNT_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (digest_high),
        .divisor   (n_live),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= TABLE_SIZE_BITS'(1024);
            base_offset_reg <= SIZE_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TABLE_SIZE:  table_size_reg  <= cfg_data[TABLE_SIZE_BITS-1:0];
                CFG_BASE_OFFSET: base_offset_reg <= cfg_data;
                default:         table_size_reg  <= table_size_reg;
            endcase
        end
    end

    // live table size: zero acts as one, oversize clamps to the memory depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_live = CNT_BITS'(1);
        end
        else if (int'(table_size_reg) > TABLE_SLOTS)
        begin
            n_live = CNT_BITS'(TABLE_SLOTS);
        end
        else
        begin
            n_live = CNT_BITS'(table_size_reg);
        end
    end

    assign new_offset = OFFSET_BITS'(base_offset_reg) + bytes_reg;
    assign probe_wrap = (CNT_BITS'(probe_addr_reg) + CNT_BITS'(1) == n_reg) ?
                        '0 : probe_addr_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        clr_addr_next     = clr_addr_reg;
        n_next            = n_reg;
        digh_next         = digh_reg;
        digm_next         = digm_reg;
        digl_next         = digl_reg;
        size_next         = size_reg;
        res_slot_next     = res_slot_reg;
        res_status_next   = res_status_reg;
        home_next         = home_reg;
        probe_addr_next   = probe_addr_reg;
        flight_next       = flight_reg;
        flight_addr_next  = flight_addr_reg;
        checked_next      = checked_reg;
        found_next        = found_reg;
        bytes_next        = bytes_reg;
        out_valid_next    = out_valid_reg && out_stall;
        slot_next         = slot_reg;
        entry_valid_next  = entry_valid_reg;
        entry_offset_next = entry_offset_reg;
        entry_size_next   = entry_size_reg;
        entry_dh_next     = entry_dh_reg;
        entry_dm_next     = entry_dm_reg;
        entry_dl_next     = entry_dl_reg;
        status_next       = status_reg;
        vmem_re           = 1'b0;
        vmem_raddr        = probe_addr_reg;
        vmem_we           = 1'b0;
        vmem_waddr        = clr_addr_reg;
        vmem_wdata        = 1'b0;
        dmem_re           = 1'b0;
        dmem_we           = 1'b0;
        mod_start         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                vmem_we = 1'b1;
                if (clr_addr_reg == SLOT_BITS'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next        = n_live;
                    digh_next     = digest_high;
                    digm_next     = digest_middle;
                    digl_next     = digest_low;
                    size_next     = object_size;
                    res_slot_next = read_slot;
                    if (command == CMD_READ)
                    begin
                        state_next = ST_DONE;
                        if (read_slot >= n_live)
                        begin
                            kind_next       = KIND_EMPTY;
                            res_status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            vmem_re         = 1'b1;
                            vmem_raddr      = SLOT_BITS'(read_slot);
                            dmem_re         = 1'b1;
                            kind_next       = KIND_READ;
                            res_status_next = STATUS_OK;
                        end
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    home_next       = SLOT_BITS'(mod_rem);
                    probe_addr_next = SLOT_BITS'(mod_rem);
                    flight_next     = 1'b0;
                    checked_next    = '0;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (flight_reg && !vrd_reg)
                begin
                    found_next      = flight_addr_reg;
                    res_slot_next   = SLOT_PORT_BITS'(flight_addr_reg);
                    kind_next       = KIND_INSERT;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end
                else if (flight_reg && (checked_reg + CNT_BITS'(1) == n_reg))
                begin
                    res_slot_next   = SLOT_PORT_BITS'(home_reg);
                    kind_next       = KIND_EMPTY;
                    res_status_next = STATUS_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    // next read issues while the previous one returns
                    vmem_re          = 1'b1;
                    vmem_raddr       = probe_addr_reg;
                    flight_next      = 1'b1;
                    flight_addr_next = probe_addr_reg;
                    probe_addr_next  = probe_wrap;
                    if (flight_reg)
                    begin
                        checked_next = checked_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = res_slot_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                    unique case (kind_reg)
                        KIND_INSERT:
                        begin
                            vmem_we           = 1'b1;
                            vmem_waddr        = found_reg;
                            vmem_wdata        = 1'b1;
                            dmem_we           = 1'b1;
                            bytes_next        = bytes_reg + OFFSET_BITS'(size_reg);
                            entry_valid_next  = 1'b1;
                            entry_offset_next = SIZE_BITS'(new_offset);
                            entry_size_next   = size_reg;
                            entry_dh_next     = digh_reg;
                            entry_dm_next     = digm_reg;
                            entry_dl_next     = digl_reg;
                        end
                        KIND_READ:
                        begin
                            entry_valid_next  = vrd_reg;
                            entry_offset_next = vrd_reg ? SIZE_BITS'(off_rd_reg) : '0;
                            entry_size_next   = vrd_reg ? size_rd_reg : '0;
                            entry_dh_next     = vrd_reg ? dh_rd_reg : '0;
                            entry_dm_next     = vrd_reg ? dm_rd_reg : '0;
                            entry_dl_next     = vrd_reg ? dl_rd_reg : '0;
                        end
                        default:
                        begin
                            entry_valid_next  = 1'b0;
                            entry_offset_next = '0;
                            entry_size_next   = '0;
                            entry_dh_next     = '0;
                            entry_dm_next     = '0;
                            entry_dl_next     = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            kind_reg         <= KIND_EMPTY;
            clr_addr_reg     <= '0;
            n_reg            <= '0;
            digh_reg         <= '0;
            digm_reg         <= '0;
            digl_reg         <= '0;
            size_reg         <= '0;
            res_slot_reg     <= '0;
            res_status_reg   <= STATUS_OK;
            home_reg         <= '0;
            probe_addr_reg   <= '0;
            flight_reg       <= 1'b0;
            flight_addr_reg  <= '0;
            checked_reg      <= '0;
            found_reg        <= '0;
            bytes_reg        <= '0;
            out_valid_reg    <= 1'b0;
            slot_reg         <= '0;
            entry_valid_reg  <= 1'b0;
            entry_offset_reg <= '0;
            entry_size_reg   <= '0;
            entry_dh_reg     <= '0;
            entry_dm_reg     <= '0;
            entry_dl_reg     <= '0;
            status_reg       <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            clr_addr_reg     <= clr_addr_next;
            n_reg            <= n_next;
            digh_reg         <= digh_next;
            digm_reg         <= digm_next;
            digl_reg         <= digl_next;
            size_reg         <= size_next;
            res_slot_reg     <= res_slot_next;
            res_status_reg   <= res_status_next;
            home_reg         <= home_next;
            probe_addr_reg   <= probe_addr_next;
            flight_reg       <= flight_next;
            flight_addr_reg  <= flight_addr_next;
            checked_reg      <= checked_next;
            found_reg        <= found_next;
            bytes_reg        <= bytes_next;
            out_valid_reg    <= out_valid_next;
            slot_reg         <= slot_next;
            entry_valid_reg  <= entry_valid_next;
            entry_offset_reg <= entry_offset_next;
            entry_size_reg   <= entry_size_next;
            entry_dh_reg     <= entry_dh_next;
            entry_dm_reg     <= entry_dm_next;
            entry_dl_reg     <= entry_dl_next;
            status_reg       <= status_next;
        end
    end

    // valid memory: probe and read port, clear and insert write port
    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            valid_mem[vmem_waddr] <= vmem_wdata;
        end
        if (vmem_re)
        begin
            vrd_reg <= valid_mem[vmem_raddr];
        end
    end

    // entry data memories
    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            offset_mem[found_reg] <= new_offset;
            size_mem[found_reg]   <= size_reg;
            dh_mem[found_reg]     <= digh_reg;
            dm_mem[found_reg]     <= digm_reg;
            dl_mem[found_reg]     <= digl_reg;
        end
        if (dmem_re)
        begin
            off_rd_reg  <= offset_mem[vmem_raddr];
            size_rd_reg <= size_mem[vmem_raddr];
            dh_rd_reg   <= dh_mem[vmem_raddr];
            dm_rd_reg   <= dm_mem[vmem_raddr];
            dl_rd_reg   <= dl_mem[vmem_raddr];
        end
    end

    assign in_stall            = (state_reg != ST_IDLE);
    assign out_valid           = out_valid_reg;
    assign slot                = slot_reg;
    assign entry_valid         = entry_valid_reg;
    assign entry_offset        = entry_offset_reg;
    assign entry_size          = entry_size_reg;
    assign entry_digest_high   = entry_dh_reg;
    assign entry_digest_middle = entry_dm_reg;
    assign entry_digest_low    = entry_dl_reg;
    assign status              = status_reg;

endmodule

// File: rtl/core/pih_mod_unit.sv
// pih_mod_unit: 64-bit remainder by a narrow divisor, two quotient bits a cycle
// restoring compare and subtract on a remainder as wide as the divisor
// depends on pih_pkg
module pih_mod_unit
    import pih_pkg::*;
#(
    parameter int CNT_BITS = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIGEST_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0]    divisor,
    output logic                   done,
    output logic [CNT_BITS-1:0]    remainder
);

    localparam int STEPS     = DIGEST_BITS / RADIX_BITS;
    localparam int STEP_BITS = $clog2(STEPS);

    logic [DIGEST_BITS-1:0] dividend_reg, dividend_next;
    logic [CNT_BITS-1:0]    divisor_reg, divisor_next;
    logic [CNT_BITS-1:0]    rem_reg, rem_next;
    logic [STEP_BITS-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_BITS-1:0]    rem_step;

    // two dependent compare-subtract steps on narrow values
    always_comb
    begin
        logic [CNT_BITS:0] trial;
        logic [CNT_BITS-1:0] r;
        r = rem_reg;
        for (int i = 0; i < RADIX_BITS; i++)
        begin
            trial = {r, dividend_reg[DIGEST_BITS-1-i]};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial = trial - {1'b0, divisor_reg};
            end
            r = trial[CNT_BITS-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            cnt_next      = '0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            dividend_next = dividend_reg << RADIX_BITS;
            rem_next      = rem_step;
            cnt_next      = cnt_reg + 1'b1;
            if (cnt_reg == STEP_BITS'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg <= '0;
            divisor_reg  <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            dividend_reg <= dividend_next;
            divisor_reg  <= divisor_next;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
